@@ design/alpha_bounding_box_crop_defines.svh @@
// Assertion macros used by the port-level checker of the alpha crop block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ALPHA_BOUNDING_BOX_CROP_DEFINES_SVH
`define ALPHA_BOUNDING_BOX_CROP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ABBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abbc assertion failed");

// Next-cycle implication, checked out of reset.
`define ABBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abbc assertion failed");

`endif

@@ design/abbc_pkg.sv @@
// Shared constants, types and helpers of the alpha bounding-box crop block.
// Depends on nothing; imported by the top level.
package abbc_pkg;

  localparam int unsigned MaxDimension = 4096;
  localparam int unsigned CoordW = $clog2(MaxDimension);   // frame position bits
  localparam int unsigned CropW  = CoordW + 1;             // crop field bits
  localparam int unsigned DimW   = 13;                     // dimension register bits
  localparam int unsigned AlphaW = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = ChanW + 2;

  // Configuration register indexes.
  localparam logic [1:0] RegImageWidth     = 2'd0;
  localparam logic [1:0] RegImageHeight    = 2'd1;
  localparam logic [1:0] RegAlphaTolerance = 2'd2;
  localparam logic [1:0] RegInvertAlpha    = 2'd3;

  localparam logic [DimW-1:0]   DimReset  = DimW'(MaxDimension);
  localparam logic [AlphaW-1:0] AlphaMax  = '1;

  // Result payload as it sits in the output register.
  typedef struct packed {
    logic [CropW-1:0]  crop_bottom;
    logic [CropW-1:0]  crop_right;
    logic [CropW-1:0]  crop_top;
    logic [CropW-1:0]  crop_left;
    logic [AlphaW-1:0] alpha;
  } result_t;

  // Sum of three bytes divided by 3: multiply by 683 and shift by 11.
  // Exact for every sum below 2048, and the sum never exceeds 765.
  function automatic logic [AlphaW-1:0] div3(input logic [SumW-1:0] sum);
    logic [SumW+10-1:0] prod;
    prod = (SumW+10)'(sum) * (SumW+10)'(683);
    return prod[AlphaW+11-1:11];
  endfunction

  // Last valid position for a dimension register: 0 acts as 1, large values clamp.
  function automatic logic [CoordW-1:0] last_index(input logic [DimW-1:0] dim);
    logic [DimW-1:0] dec;
    dec = dim - DimW'(1);
    if (dim == '0) begin
      return '0;
    end else if (dim > DimW'(MaxDimension)) begin
      return CoordW'(MaxDimension - 1);
    end else begin
      return dec[CoordW-1:0];
    end
  endfunction

endpackage

@@ design/alpha_bounding_box_crop.sv @@
// Alpha bounding-box crop: derives alpha per pixel and reports the crop rectangle.
// Depends on abbc_pkg for widths, the result struct and the divide-by-3 helper.
// One pixel is taken per clock whenever the result register is empty or being
// drained; its result appears in the next cycle, all work being done combinationally
// between the input stream and the result register. With out_tready held
// high the block sustains one pixel per clock; a stalled result stalls input
// through the single result register. Every pixel gives one result; the last
// pixel of a frame carries tlast and the crop rectangle (left, top inclusive;
// right, bottom one past the last opaque column and row; (0,0,1,1) when no
// pixel was opaque). Configuration writes do not reset the frame position.
module alpha_bounding_box_crop
  import abbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  // Pixel stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // blue[7:0], green[15:8], red[23:16]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // alpha[7:0], crop_left[20:8], crop_top[33:21],
                                   // crop_right[46:34], crop_bottom[59:47], zeros
  output logic        out_tlast    // frame_done
);

  // Configuration registers.
  logic [DimW-1:0]   width_r;
  logic [DimW-1:0]   height_r;
  logic [AlphaW-1:0] tolerance_r;
  logic              invert_r;

  // Frame state.
  logic [CoordW-1:0] col_r, col_nxt;
  logic [CoordW-1:0] row_r, row_nxt;
  logic              found_r, found_nxt;
  logic [CoordW-1:0] min_row_r, min_row_nxt;
  logic [CoordW-1:0] max_row_r, max_row_nxt;
  logic [CoordW-1:0] min_col_r, min_col_nxt;
  logic [CoordW-1:0] max_col_r, max_col_nxt;

  // Result register.
  logic    out_valid_r;
  logic    out_last_r, out_last_nxt;
  result_t result_r, result_nxt;

  logic              in_fire;
  logic [ChanW-1:0]  blue, green, red;
  logic [SumW-1:0]   chan_sum;
  logic [AlphaW-1:0] avg;
  logic [AlphaW-1:0] alpha;
  logic              opaque;
  logic              last_col;
  logic              last_row;

  // The result register accepts a new pixel when empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DimReset;
      height_r    <= DimReset;
      tolerance_r <= '0;
      invert_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegImageWidth:     width_r     <= cfg_wdata;
        RegImageHeight:    height_r    <= cfg_wdata;
        RegAlphaTolerance: tolerance_r <= cfg_wdata[AlphaW-1:0];
        RegInvertAlpha:    invert_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Alpha of the incoming pixel.
  assign blue     = in_tdata[7:0];
  assign green    = in_tdata[15:8];
  assign red      = in_tdata[23:16];
  assign chan_sum = SumW'(blue) + SumW'(green) + SumW'(red);
  assign avg      = div3(chan_sum);
  assign alpha    = invert_r ? (AlphaMax - avg) : avg;
  assign opaque   = alpha > tolerance_r;

  // Position within the frame; a position past a shrunk dimension counts as last.
  assign last_col = col_r >= last_index(width_r);
  assign last_row = row_r >= last_index(height_r);

  // Box update, frame position and result for the pixel.
  always_comb begin
    found_nxt   = found_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    if (opaque) begin
      if (!found_r) begin
        found_nxt   = 1'b1;
        min_row_nxt = row_r;
        max_row_nxt = row_r;
        min_col_nxt = col_r;
        max_col_nxt = col_r;
      end else begin
        if (row_r < min_row_r) min_row_nxt = row_r;
        if (row_r > max_row_r) max_row_nxt = row_r;
        if (col_r < min_col_r) min_col_nxt = col_r;
        if (col_r > max_col_r) max_col_nxt = col_r;
      end
    end

    result_nxt       = '0;
    result_nxt.alpha = alpha;
    out_last_nxt     = 1'b0;
    col_nxt          = col_r;
    row_nxt          = row_r;

    if (last_col && last_row) begin
      out_last_nxt = 1'b1;
      if (found_nxt) begin
        result_nxt.crop_left   = CropW'(min_col_nxt);
        result_nxt.crop_top    = CropW'(min_row_nxt);
        result_nxt.crop_right  = CropW'(max_col_nxt) + CropW'(1);
        result_nxt.crop_bottom = CropW'(max_row_nxt) + CropW'(1);
      end else begin
        result_nxt.crop_right  = CropW'(1);
        result_nxt.crop_bottom = CropW'(1);
      end
      // A new frame starts with an empty box.
      col_nxt     = '0;
      row_nxt     = '0;
      found_nxt   = 1'b0;
      min_row_nxt = '0;
      max_row_nxt = '0;
      min_col_nxt = '0;
      max_col_nxt = '0;
    end else if (last_col) begin
      col_nxt = '0;
      row_nxt = row_r + CoordW'(1);
    end else begin
      col_nxt = col_r + CoordW'(1);
    end
  end

  // Frame state advances on each accepted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      found_r   <= 1'b0;
      min_row_r <= '0;
      max_row_r <= '0;
      min_col_r <= '0;
      max_col_r <= '0;
    end else if (in_fire) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      found_r   <= found_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r   <= result_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, result_r};

endmodule

@@ design/abbc_checker.sv @@
// Port-level checker for the alpha crop block, bound to its top level.
// Depends on the assertion macros in alpha_bounding_box_crop_defines.svh.
`include "alpha_bounding_box_crop_defines.svh"

module abbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // Result fields and handshake state seen on the ports.
  logic [12:0] crop_left, crop_top, crop_right, crop_bottom;
  logic [64:0] out_beat;
  logic        out_stall;
  logic        crop_wide;
  logic        crop_tall;

  assign crop_left   = out_tdata[20:8];
  assign crop_top    = out_tdata[33:21];
  assign crop_right  = out_tdata[46:34];
  assign crop_bottom = out_tdata[59:47];
  assign out_beat    = {out_tlast, out_tdata};
  assign out_stall   = out_tvalid && !out_tready;
  assign crop_wide   = crop_right > crop_left;
  assign crop_tall   = crop_bottom > crop_top;

  // A stalled result holds its payload.
  `ABBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_beat))

  // Every accepted pixel leaves a result waiting in the next cycle.
  `ABBC_ASSERT_NEXT(a_in_to_out, clk, rst_n, in_tvalid && in_tready, out_tvalid)

  // No pixel is taken while a result is stalled.
  `ABBC_ASSERT_NOW(a_no_overrun, clk, rst_n, out_stall, !in_tready)

  // Crop fields are zero except on a frame's last pixel.
  `ABBC_ASSERT_NOW(a_crop_zero, clk, rst_n, out_tvalid && !out_tlast, out_tdata[63:8] == 56'd0)

  // A reported rectangle is never empty.
  `ABBC_ASSERT_NOW(a_crop_order, clk, rst_n, out_tvalid && out_tlast, crop_wide && crop_tall)

endmodule

bind alpha_bounding_box_crop abbc_checker u_abbc_checker (.*);

@@ sim/alpha_bounding_box_crop_checker.sv @@
// Result checker for the alpha bounding-box crop block: tracks register writes and pixel
// transfers, predicts each result and compares it with the result stream.
// Depends on abbc_pkg for field widths, register indexes and the maximum dimension.
`timescale 1ns / 1ps

module alpha_bounding_box_crop_checker
  import abbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [DimW-1:0]   cfg_wdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,    // blue[7:0], green[15:8], red[23:16]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [63:0]       out_tdata,   // alpha, crop_left, crop_top, crop_right,
                                         // crop_bottom, zeros
  input  logic              out_tlast,   // frame_done
  output int unsigned       fail_count,
  output int unsigned       results_pending
);

  // Bit offsets of the result fields in out_tdata.
  localparam int unsigned LeftLsb   = AlphaW;
  localparam int unsigned TopLsb    = LeftLsb + CropW;
  localparam int unsigned RightLsb  = TopLsb + CropW;
  localparam int unsigned BottomLsb = RightLsb + CropW;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic              frame_done;
    logic [CropW-1:0]  left;
    logic [CropW-1:0]  top;
    logic [CropW-1:0]  right;
    logic [CropW-1:0]  bottom;
  } crop_result_t;

  crop_result_t crop_results_q[$];

  // Shadow copy of the registers.
  logic [DimW-1:0]   width_reg;
  logic [DimW-1:0]   height_reg;
  logic [AlphaW-1:0] tolerance_reg;
  logic              invert_reg;

  // Frame position and the box of opaque pixels seen so far.
  logic [CoordW-1:0] col_pos;
  logic [CoordW-1:0] row_pos;
  logic              box_found;
  logic [CoordW-1:0] box_min_row;
  logic [CoordW-1:0] box_max_row;
  logic [CoordW-1:0] box_min_col;
  logic [CoordW-1:0] box_max_col;

  initial begin
    fail_count      = 0;
    results_pending = 0;
  end

  function automatic int unsigned effective_dim(input logic [DimW-1:0] dim);
    if (dim == '0) begin
      return 1;
    end else if (dim > MaxDimension) begin
      return MaxDimension;
    end
    return 32'(dim);
  endfunction

  task automatic clear_box();
    col_pos     = '0;
    row_pos     = '0;
    box_found   = 1'b0;
    box_min_row = '0;
    box_max_row = '0;
    box_min_col = '0;
    box_max_col = '0;
  endtask

  // Works out the alpha and, on the last pixel of a frame, the crop rectangle.
  task automatic predict_pixel(input logic [23:0] px);
    int unsigned  chan_sum;
    int unsigned  average;
    int unsigned  w;
    int unsigned  h;
    logic [AlphaW-1:0] alpha;
    bit           last_col;
    bit           last_row;
    crop_result_t want;
    chan_sum = 32'(px[7:0]) + 32'(px[15:8]) + 32'(px[23:16]);
    average  = chan_sum / 3;
    alpha    = invert_reg ? AlphaW'(255 - average) : AlphaW'(average);
    w        = effective_dim(width_reg);
    h        = effective_dim(height_reg);
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);

    // Grow the box around an opaque pixel.
    if (alpha > tolerance_reg) begin
      if (!box_found) begin
        box_found   = 1'b1;
        box_min_row = row_pos;
        box_max_row = row_pos;
        box_min_col = col_pos;
        box_max_col = col_pos;
      end else begin
        if (row_pos < box_min_row) box_min_row = row_pos;
        if (row_pos > box_max_row) box_max_row = row_pos;
        if (col_pos < box_min_col) box_min_col = col_pos;
        if (col_pos > box_max_col) box_max_col = col_pos;
      end
    end

    want       = '0;
    want.alpha = alpha;
    if (last_col && last_row) begin
      want.frame_done = 1'b1;
      if (box_found) begin
        want.left   = CropW'(box_min_col);
        want.top    = CropW'(box_min_row);
        want.right  = CropW'(box_max_col) + CropW'(1);
        want.bottom = CropW'(box_max_row) + CropW'(1);
      end else begin
        want.right  = CropW'(1);
        want.bottom = CropW'(1);
      end
      clear_box();
    end else if (last_col) begin
      col_pos = '0;
      row_pos = row_pos + CoordW'(1);
    end else begin
      col_pos = col_pos + CoordW'(1);
    end
    crop_results_q.push_back(want);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    crop_result_t want;
    if (crop_results_q.size() == 0) begin
      fail_count++;
      $display("%0t: result with no pixel outstanding, expected none actual tdata %h tlast %b",
               $time, out_tdata, out_tlast);
    end else begin
      want = crop_results_q.pop_front();
      compare_field("alpha", 32'(want.alpha), 32'(out_tdata[LeftLsb-1:0]));
      compare_field("frame_done", 32'(want.frame_done), 32'(out_tlast));
      compare_field("crop_left", 32'(want.left), 32'(out_tdata[LeftLsb +: CropW]));
      compare_field("crop_top", 32'(want.top), 32'(out_tdata[TopLsb +: CropW]));
      compare_field("crop_right", 32'(want.right), 32'(out_tdata[RightLsb +: CropW]));
      compare_field("crop_bottom", 32'(want.bottom), 32'(out_tdata[BottomLsb +: CropW]));
    end
  endtask

  // A pixel transfer sees the registers as they were before this edge; a register
  // write at the same edge only affects later pixels. The result transfer comes last.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg     = DimW'(MaxDimension);
      height_reg    = DimW'(MaxDimension);
      tolerance_reg = '0;
      invert_reg    = 1'b0;
      clear_box();
      crop_results_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_pixel(in_tdata);
      if (cfg_wr_en) begin
        case (cfg_index)
          RegImageWidth:     width_reg = cfg_wdata;
          RegImageHeight:    height_reg = cfg_wdata;
          RegAlphaTolerance: tolerance_reg = cfg_wdata[AlphaW-1:0];
          RegInvertAlpha:    invert_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
    end
    results_pending = crop_results_q.size();
  end

endmodule

@@ sim/tb_alpha_bounding_box_crop.sv @@
// Top testbench of the alpha bounding-box crop block: clock, reset, register writes,
// pixel stimulus with random gaps, result back-pressure and the final verdict.
// Depends on abbc_pkg, alpha_bounding_box_crop and alpha_bounding_box_crop_checker.
`timescale 1ns / 1ps

module tb_alpha_bounding_box_crop;
  import abbc_pkg::*;

  localparam int unsigned RandomPixels   = 1300;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned LongHoldAfter  = 300;
  localparam int unsigned LongHoldCycles = 150;
  localparam int unsigned SettleCycles   = 4;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [DimW-1:0]   cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;    // blue[7:0], green[15:8], red[23:16]
  logic              out_tvalid;
  logic              out_tready;
  logic [63:0]       out_tdata;   // alpha[7:0], crop_left[20:8], crop_top[33:21],
                                  // crop_right[46:34], crop_bottom[59:47], zeros
  logic              out_tlast;   // frame_done

  int unsigned       fail_count;
  int unsigned       results_pending;
  int unsigned       cycle_count;
  bit                sender_burst;

  alpha_bounding_box_crop dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  alpha_bounding_box_crop_checker crop_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: after each transfer, hold off for a random number of cycles. Once,
  // while pixels are being offered, hold off for a long stretch so the block backs up.
  initial begin
    int unsigned results_taken;
    int unsigned hold_left;
    bit          took;
    bit          long_hold_done;
    bit          steady;
    out_tready     = 1'b0;
    results_taken  = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    steady         = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      took = out_tvalid && out_tready;
      @(negedge clk);
      if (took) begin
        results_taken++;
        if (results_taken % 64 == 0) steady = ($urandom_range(0, 2) == 0);
        hold_left = steady ? 0 : $urandom_range(0, 10);
      end
      if (!long_hold_done && results_taken >= LongHoldAfter && in_tvalid) begin
        long_hold_done = 1'b1;
        hold_left      = LongHoldCycles;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Writes all four registers on consecutive cycles; call only while the block is idle.
  task automatic apply_config(input int unsigned width, input int unsigned height,
                              input int unsigned tolerance, input bit invert);
    cfg_wr_en <= 1'b1;
    cfg_index <= RegImageWidth;
    cfg_wdata <= DimW'(width);
    @(negedge clk);
    cfg_index <= RegImageHeight;
    cfg_wdata <= DimW'(height);
    @(negedge clk);
    cfg_index <= RegAlphaTolerance;
    cfg_wdata <= DimW'(tolerance);
    @(negedge clk);
    cfg_index <= RegInvertAlpha;
    cfg_wdata <= DimW'(invert);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one pixel after a random gap and returns at the falling edge after its transfer.
  task automatic push_pixel(input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {red, green, blue};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mostly background pixels that stay transparent, with random and saturated ones mixed in.
  task automatic push_random_pixel(input bit invert);
    int unsigned pick;
    logic [7:0]  level;
    pick  = $urandom_range(0, 9);
    level = invert ? 8'hFF : 8'h00;
    if (pick < 6) begin
      push_pixel(level, level, level);
    end else if (pick < 9) begin
      push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end else begin
      level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      push_pixel(level, level, level);
    end
  endtask

  // Stops offering pixels and waits until every result has come back.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic int unsigned draw_dimension(input int unsigned typical_max);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(MaxDimension + 1, 8191);
      2:       return MaxDimension;
      3:       return 8191;
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_pixels;
    int unsigned width;
    int unsigned height;
    int unsigned tolerance;
    bit          invert;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = RegImageWidth;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    sender_burst = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, then a shrink to one pixel while mid-row ends the frame at once.
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);
    wait_drain();
    apply_config(1, 1, 0, 0);
    push_pixel(8'h00, 8'h00, 8'h00);
    wait_drain();

    // Small frame with one opaque pixel per row, the second of them barely opaque.
    apply_config(3, 2, 0, 0);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'h02, 8'h01, 8'h00);
    push_pixel(8'h01, 8'h01, 8'h00);
    wait_drain();

    // Top tolerance: nothing is opaque, so each one-pixel frame reports the empty box.
    apply_config(1, 1, 255, 0);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);
    wait_drain();

    // Inverted alpha with a zero width that acts as one column.
    apply_config(0, 3, 254, 1);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_drain();

    // Oversized width, then a shrink below the current column mid-frame.
    apply_config(8191, MaxDimension, 0, 0);
    push_pixel(8'h0A, 8'h14, 8'h1E);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'h00, 8'hFF, 8'h00);
    wait_drain();
    apply_config(2, 1, 0, 0);
    push_pixel(8'h00, 8'h00, 8'h00);
    wait_drain();

    // Zero height acts as one row.
    apply_config(2, 0, 100, 0);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFE);
    wait_drain();

    // Random phases: each one picks settings, streams pixels and drains before the next.
    sent = 0;
    while (sent < RandomPixels) begin
      width  = draw_dimension(10);
      height = draw_dimension(8);
      case ($urandom_range(0, 9))
        0:       tolerance = 0;
        1:       tolerance = 255;
        default: tolerance = $urandom_range(0, 255);
      endcase
      invert = 1'($urandom_range(0, 1));
      apply_config(width, height, tolerance, invert);
      sender_burst = ($urandom_range(0, 3) == 0);
      phase_pixels = $urandom_range(20, 60);
      repeat (phase_pixels) push_random_pixel(invert);
      sent += phase_pixels;
      wait_drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/abbc_pkg.sv
design/alpha_bounding_box_crop.sv
design/abbc_checker.sv
sim/alpha_bounding_box_crop_checker.sv
sim/tb_alpha_bounding_box_crop.sv
